// ----- rtl/matrix_keypad_debounce_reporter_macros.svh -----
// Assertion helpers shared by the keypad reporter modules.
`ifndef MATRIX_KEYPAD_DEBOUNCE_REPORTER_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCE_REPORTER_MACROS_SVH

// Same-cycle implication.
`define MKDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MKDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mkdr_pkg.sv -----
`default_nettype none
package mkdr_pkg;

  localparam int ROWS  = 8;
  localparam int COLS  = 8;
  localparam int NKEYS = ROWS * COLS;

  localparam int SHIFT_BIT  = 5 * COLS;
  localparam int CTRL_BIT   = 5 * COLS + 1;
  localparam int ALT_BIT    = 6 * COLS + 1;
  localparam int SYMBOL_BIT = 7 * COLS + 1;

  localparam logic [NKEYS-1:0] MOD_MASK =
    (64'd1 << SHIFT_BIT) | (64'd1 << CTRL_BIT) | (64'd1 << ALT_BIT);
  localparam logic [NKEYS-1:0] SYM_MASK = 64'd1 << SYMBOL_BIT;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_SYNC    = 2'd2;

  localparam logic [1:0] PASS_MOD_PRESS   = 2'd0;
  localparam logic [1:0] PASS_KEY_PRESS   = 2'd1;
  localparam logic [1:0] PASS_KEY_RELEASE = 2'd2;
  localparam logic [1:0] PASS_MOD_RELEASE = 2'd3;

  localparam logic REG_DEBOUNCE = 1'b0;

  localparam logic [8:0] BASE_MAP [NKEYS] = '{
    9'd116, 9'd217, 9'd59,  9'd60,  9'd61,  9'd62,  9'd102, 9'd139,
    9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd58,  9'd156, 9'd0,
    9'd16,  9'd17,  9'd18,  9'd19,  9'd20,  9'd21,  9'd22,  9'd23,
    9'd30,  9'd31,  9'd32,  9'd33,  9'd34,  9'd35,  9'd24,  9'd25,
    9'd44,  9'd45,  9'd46,  9'd47,  9'd48,  9'd36,  9'd37,  9'd38,
    9'd42,  9'd29,  9'd0,   9'd0,   9'd0,   9'd49,  9'd50,  9'd12,
    9'd0,   9'd56,  9'd115, 9'd418, 9'd105, 9'd103, 9'd108, 9'd106,
    9'd57,  9'd0,   9'd114, 9'd419, 9'd1,   9'd28,  9'd14,  9'd111
  };

  localparam logic [8:0] SYM_MAP [NKEYS] = '{
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd2, 9'd3, 9'd4,  9'd5,  9'd6,  9'd7,  9'd8,  9'd9,
    9'd0, 9'd0, 9'd41, 9'd13, 9'd43, 9'd39, 9'd10, 9'd11,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd40, 9'd26, 9'd27,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd51, 9'd52, 9'd53,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0
  };

  typedef struct packed {
    logic accept;
    logic take_cand;
    logic start_report;
    logic advance;
    logic press_write;
    logic rel_read;
    logic rel_finish;
    logic emit_sync;
  } ctl_cmd_t;

  typedef struct packed {
    logic cand_diff;
    logic stable_diff;
    logic due;
    logic bit_set;
    logic is_release;
    logic press_nz;
    logic rel_nz;
    logic last_pos;
    logic out_free;
  } ctl_sts_t;

  function automatic logic in_symbol_layer(input logic [5:0] pos);
    logic [2:0] row;
    logic [2:0] col;
    row = pos[5:3];
    col = pos[2:0];
    return (row == 3'd2) || (row == 3'd3) || (row == 3'd4) ||
           ((row == 3'd5) && (col >= 3'd5));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/matrix_keypad_debounce_reporter.sv -----
// A word is taken in the idle state and evaluated in the next cycle; a word that starts no report
// returns to idle. A report scans 4 passes of 64 key positions, one position a cycle unless an
// output stall holds it, plus a code memory read state per release, then one sync word.
// Output stalls hold the scan; the input is stalled until the report's sync is loaded.
// Reset (rst, synchronous): debounce_ms 20, key sets and time zero, stored codes marked invalid.
`default_nettype none
module matrix_keypad_debounce_reporter
  import mkdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] key_matrix,
  input  wire logic [31:0] now_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  event_kind,
  output logic      [8:0]  key_code,
  output logic      [5:0]  key_position,
  output logic             last_event
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  mkdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mkdr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_sel      (paddr[2]),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata),
    .key_matrix   (key_matrix),
    .now_ms       (now_ms),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .event_kind   (event_kind),
    .key_code     (key_code),
    .key_position (key_position),
    .last_event   (last_event),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule
`default_nettype wire

// ----- rtl/mkdr_ctrl.sv -----
`default_nettype none
`include "matrix_keypad_debounce_reporter_macros.svh"
module mkdr_ctrl
  import mkdr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_RELW = 3'd3;
  localparam logic [2:0] ST_SYNC = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.cand_diff) begin
          cmd.take_cand = 1'b1;
          state_next = ST_IDLE;
        end else if (sts.stable_diff && sts.due) begin
          cmd.start_report = 1'b1;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts.bit_set) begin
          cmd.advance = 1'b1;
          if (sts.last_pos) state_next = ST_SYNC;
        end else if (sts.is_release) begin
          cmd.rel_read = 1'b1;
          state_next = ST_RELW;
        end else if (!sts.press_nz || sts.out_free) begin
          cmd.press_write = 1'b1;
          cmd.advance = 1'b1;
          if (sts.last_pos) state_next = ST_SYNC;
        end
      end
      ST_RELW: begin
        if (!sts.rel_nz || sts.out_free) begin
          cmd.rel_finish = 1'b1;
          cmd.advance = 1'b1;
          state_next = sts.last_pos ? ST_SYNC : ST_SCAN;
        end
      end
      ST_SYNC: begin
        if (sts.out_free) begin
          cmd.emit_sync = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `MKDR_ASSERT_IMP(a_eval_after_idle, state == ST_EVAL, $past(state) == ST_IDLE,
    "evaluation entered without an accepted word")
  `MKDR_ASSERT_IMP(a_relw_from_scan, state == ST_RELW,
    $past(state) == ST_SCAN || $past(state) == ST_RELW,
    "release fetch outside a scan")
  `MKDR_ASSERT_IMP(a_sync_from_scan, state == ST_SYNC,
    $past(state) == ST_SCAN || $past(state) == ST_RELW || $past(state) == ST_SYNC,
    "sync reached without a scan")

endmodule
`default_nettype wire

// ----- rtl/mkdr_datapath.sv -----
`default_nettype none
`include "matrix_keypad_debounce_reporter_macros.svh"
module mkdr_datapath
  import mkdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_sel,
  input  wire logic [31:0] cfg_wdata,
  output logic      [31:0] cfg_rdata,
  input  wire logic [63:0] key_matrix,
  input  wire logic [31:0] now_ms,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic      [1:0]  event_kind,
  output logic      [8:0]  key_code,
  output logic      [5:0]  key_position,
  output logic             last_event,
  input  wire ctl_cmd_t    cmd,
  output ctl_sts_t         sts
);

  logic [NKEYS-1:0] in_keys;
  logic [31:0]      in_now;
  logic [NKEYS-1:0] cand_keys;
  logic [NKEYS-1:0] stable_keys;
  logic [31:0]      cand_time;
  logic [15:0]      debounce_ms;
  logic [NKEYS-1:0] press_mask;
  logic [NKEYS-1:0] rel_mask;
  logic             sym_held;
  logic [1:0]       pass;
  logic [5:0]       pos;
  logic [8:0]       code_mem [NKEYS];
  logic [NKEYS-1:0] code_valid;
  logic [8:0]       rdata;
  logic             rvalid;

  logic [NKEYS-1:0] pass_mask;
  logic [NKEYS-1:0] changed;
  logic [31:0]      deadline;
  logic [31:0]      age;
  logic [8:0]       press_code;
  logic [8:0]       rel_code;
  logic             out_free;
  logic             load_out;

  assign cfg_rdata = (cfg_sel == REG_DEBOUNCE) ? {16'd0, debounce_ms} : 32'd0;

  always_comb begin
    case (pass)
      PASS_MOD_PRESS:   pass_mask = press_mask & MOD_MASK;
      PASS_KEY_PRESS:   pass_mask = press_mask & ~(MOD_MASK | SYM_MASK);
      PASS_KEY_RELEASE: pass_mask = rel_mask & ~(MOD_MASK | SYM_MASK);
      default:          pass_mask = rel_mask & MOD_MASK;
    endcase
  end

  assign changed    = in_keys ^ stable_keys;
  assign deadline   = cand_time + {16'd0, debounce_ms};
  assign age        = in_now - deadline;
  assign press_code = ((pass == PASS_KEY_PRESS) && sym_held && in_symbol_layer(pos)) ?
                      SYM_MAP[pos] : BASE_MAP[pos];
  assign rel_code   = rvalid ? rdata : 9'd0;
  assign out_free   = !out_valid || !out_stall;
  assign load_out   = (cmd.press_write && (press_code != 9'd0)) ||
                      (cmd.rel_finish && (rel_code != 9'd0)) || cmd.emit_sync;

  always_comb begin
    sts.cand_diff   = (in_keys != cand_keys);
    sts.stable_diff = (in_keys != stable_keys);
    sts.due         = !age[31];
    sts.bit_set     = pass_mask[pos];
    sts.is_release  = pass[1];
    sts.press_nz    = (press_code != 9'd0);
    sts.rel_nz      = (rel_code != 9'd0);
    sts.last_pos    = &{pass, pos};
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write && (cfg_sel == REG_DEBOUNCE)) begin
      debounce_ms <= cfg_wdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_keys <= key_matrix;
      in_now  <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_keys   <= '0;
      cand_time   <= '0;
      stable_keys <= '0;
    end else if (cmd.take_cand) begin
      cand_keys <= in_keys;
      cand_time <= in_now;
    end else if (cmd.start_report) begin
      stable_keys <= in_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_report) begin
      press_mask  <= changed & in_keys;
      rel_mask    <= changed & ~in_keys;
      sym_held    <= in_keys[SYMBOL_BIT];
      {pass, pos} <= '0;
    end else if (cmd.advance) begin
      {pass, pos} <= {pass, pos} + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.press_write) code_mem[pos] <= press_code;
    if (cmd.rel_read) begin
      rdata  <= code_mem[pos];
      rvalid <= code_valid[pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= '0;
    end else if (cmd.press_write) begin
      code_valid[pos] <= 1'b1;
    end else if (cmd.rel_finish) begin
      code_valid[pos] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (cmd.emit_sync) begin
        event_kind   <= EV_SYNC;
        key_code     <= 9'd0;
        key_position <= 6'd0;
        last_event   <= 1'b1;
      end else begin
        event_kind   <= cmd.rel_finish ? EV_RELEASE : EV_PRESS;
        key_code     <= cmd.rel_finish ? rel_code : press_code;
        key_position <= pos;
        last_event   <= 1'b0;
      end
    end
  end

  `MKDR_ASSERT_IMP(a_load_when_free, load_out, out_free,
    "output word overwritten while stalled")
  `MKDR_ASSERT_IMP(a_release_on_set_bit, cmd.rel_finish, sts.is_release && sts.bit_set,
    "release finished on a position outside the release mask")
  `MKDR_ASSERT_NXT(a_sync_word, cmd.emit_sync,
    out_valid && last_event && event_kind == EV_SYNC && key_code == 9'd0,
    "sync word malformed")

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench
  import mkdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHIFT_POS = 40;
  localparam int CTRL_POS = 41;
  localparam int ALT_POS = 49;
  localparam int SYM_POS = 57;
  localparam logic [63:0] MODS = (64'd1 << SHIFT_POS) | (64'd1 << CTRL_POS) | (64'd1 << ALT_POS);
  localparam logic [63:0] SYMK = 64'd1 << SYM_POS;
  localparam logic [15:0] RESET_SETTLE = 16'd20;

  localparam logic [2:0] DEBOUNCE_ADDR = 3'd0;
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

  localparam int IDLE_GAP = 20;
  localparam int LONG_HOLD = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_POLLS = 31;
  localparam int NUM_PHASES = 6;

  localparam logic [8:0] BASE_CODE [64] = '{
    9'd116, 9'd217, 9'd59,  9'd60,  9'd61,  9'd62,  9'd102, 9'd139,
    9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd58,  9'd156, 9'd0,
    9'd16,  9'd17,  9'd18,  9'd19,  9'd20,  9'd21,  9'd22,  9'd23,
    9'd30,  9'd31,  9'd32,  9'd33,  9'd34,  9'd35,  9'd24,  9'd25,
    9'd44,  9'd45,  9'd46,  9'd47,  9'd48,  9'd36,  9'd37,  9'd38,
    9'd42,  9'd29,  9'd0,   9'd0,   9'd0,   9'd49,  9'd50,  9'd12,
    9'd0,   9'd56,  9'd115, 9'd418, 9'd105, 9'd103, 9'd108, 9'd106,
    9'd57,  9'd0,   9'd114, 9'd419, 9'd1,   9'd28,  9'd14,  9'd111
  };

  localparam logic [8:0] SYM_CODE [64] = '{
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd2, 9'd3, 9'd4,  9'd5,  9'd6,  9'd7,  9'd8,  9'd9,
    9'd0, 9'd0, 9'd41, 9'd13, 9'd43, 9'd39, 9'd10, 9'd11,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd40, 9'd26, 9'd27,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd51, 9'd52, 9'd53,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,
    9'd0, 9'd0, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] code;
    logic [5:0] pos;
    logic       last;
  } key_event_t;

  typedef enum logic [1:0] {ROW_POLL, ROW_SETTLE, ROW_STRAY} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [63:0] keys;
    logic [31:0] now;
    logic        typed;
    logic [1:0]  n;
    logic [1:0]  kind;
    logic [8:0]  code;
    logic [5:0]  pos;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] key_matrix = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [8:0]  key_code;
  logic [5:0]  key_position;
  logic        last_event;

  logic [63:0] cand_keys = '0;
  logic [63:0] stable_keys = '0;
  logic [31:0] cand_time = '0;
  logic [8:0]  held_code [64];
  logic [15:0] settle_ms = RESET_SETTLE;

  key_event_t  report_events[$];
  key_event_t  events_due[$];
  plan_row_t   plan[$];

  logic [31:0] clock_ms = '0;
  bit          quiet = 1'b0;
  bit          hold_armed = 1'b0;
  int          mismatches = 0;
  int          polls_sent = 0;
  int          events_seen = 0;
  int          reports_seen = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;

  matrix_keypad_debounce_reporter dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .key_matrix(key_matrix), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .key_code(key_code),
    .key_position(key_position), .last_event(last_event)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic key_event_t mk_event(input logic [1:0] k, input logic [8:0] c,
                                          input logic [5:0] p, input logic l);
    return {k, c, p, l};
  endfunction

  function automatic logic sym_layer(input int p);
    return (p >= 16 && p < 40) || (p >= 45 && p < 48);
  endfunction

  task automatic scan_press(input logic [63:0] mask, input logic sym);
    logic [8:0] c;
    for (int p = 0; p < 64; p++) begin
      if (mask[p]) begin
        c = (sym && sym_layer(p)) ? SYM_CODE[p] : BASE_CODE[p];
        held_code[p] = c;
        if (c != 9'd0) report_events.push_back(mk_event(EV_PRESS, c, 6'(p), 1'b0));
      end
    end
  endtask

  task automatic scan_release(input logic [63:0] mask);
    for (int p = 0; p < 64; p++) begin
      if (mask[p]) begin
        if (held_code[p] != 9'd0) begin
          report_events.push_back(mk_event(EV_RELEASE, held_code[p], 6'(p), 1'b0));
        end
        held_code[p] = 9'd0;
      end
    end
  endtask

  task automatic predict_poll(input logic [63:0] keys, input logic [31:0] now);
    logic [63:0] changed;
    logic [63:0] rise;
    logic [63:0] fall;
    logic [31:0] age;
    report_events.delete();
    if (keys != cand_keys) begin
      cand_keys = keys;
      cand_time = now;
    end else if (keys != stable_keys) begin
      age = now - (cand_time + 32'(settle_ms));
      if (!age[31]) begin
        changed = keys ^ stable_keys;
        rise = changed & keys;
        fall = changed & ~keys;
        scan_press(rise & MODS, 1'b0);
        scan_press(rise & ~MODS & ~SYMK, keys[SYM_POS]);
        scan_release(fall & ~MODS & ~SYMK);
        scan_release(fall & MODS);
        stable_keys = keys;
        report_events.push_back(mk_event(EV_SYNC, 9'd0, 6'd0, 1'b1));
      end
    end
  endtask

  function automatic plan_row_t plan_entry(input row_op_t op, input logic [63:0] keys,
                                           input logic [31:0] now, input logic typed,
                                           input logic [1:0] n, input logic [1:0] kind,
                                           input logic [8:0] code, input logic [5:0] pos);
    return {op, keys, now, typed, n, kind, code, pos};
  endfunction

  task automatic send_poll(input plan_row_t row);
    key_matrix <= row.keys;
    now_ms <= row.now;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polls_sent++;
    predict_poll(row.keys, row.now);
    if (row.typed) begin
      if (row.n == 2'd2) events_due.push_back(mk_event(row.kind, row.code, row.pos, 1'b0));
      if (row.n != 2'd0) events_due.push_back(mk_event(EV_SYNC, 9'd0, 6'd0, 1'b1));
    end else begin
      foreach (report_events[i]) events_due.push_back(report_events[i]);
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic poll_model(input logic [63:0] keys, input logic [31:0] now);
    send_poll(plan_entry(ROW_POLL, keys, now, 1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == DEBOUNCE_ADDR) begin
      settle_ms = data[15:0];
      settings_used++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= DEBOUNCE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== {16'd0, settle_ms}) begin
      report_mismatch("debounce_ms readback", 64'(rd), 64'(settle_ms));
    end
  endtask

  function automatic logic [63:0] sparse_keys();
    logic [63:0] k;
    k = '0;
    repeat ($urandom_range(1, 4)) k[6'($urandom_range(0, 63))] = 1'b1;
    return k;
  endfunction

  task automatic step_clock();
    case ($urandom_range(0, 9))
      0: clock_ms -= $urandom_range(1, 50);
      1: clock_ms = $urandom;
      2, 3, 4: clock_ms += $urandom_range(0, settle_ms);
      default: clock_ms += 32'(settle_ms) + $urandom_range(0, 40);
    endcase
  endtask

  task automatic run_burst();
    logic [63:0] target;
    case ($urandom_range(0, 7))
      0: target = '0;
      1: target = '1;
      2: target = {$urandom, $urandom};
      3: target = stable_keys ^ (64'd1 << $urandom_range(0, 63));
      4: target = sparse_keys();
      5: target = sparse_keys() | SYMK;
      6: target = sparse_keys() | (MODS & {$urandom, $urandom});
      default: target = stable_keys ^ sparse_keys();
    endcase
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 20);
        poll_model({$urandom, $urandom}, clock_ms);
      end
    end else begin
      repeat ($urandom_range(0, 2)) begin
        clock_ms += $urandom_range(0, 5);
        poll_model(target ^ sparse_keys(), clock_ms);
      end
      clock_ms += $urandom_range(0, 5);
      poll_model(target, clock_ms);
      repeat ($urandom_range(1, 3)) begin
        step_clock();
        poll_model(target, clock_ms);
      end
    end
  endtask

  always @(posedge clk) begin : rx_check
    key_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        report_mismatch("word with nothing expected",
                        64'({event_kind, key_code, key_position, last_event}), 64'd0);
      end else begin
        want = events_due.pop_front();
        if (event_kind !== want.kind) begin
          report_mismatch("event_kind", 64'(event_kind), 64'(want.kind));
        end
        if (key_code !== want.code) begin
          report_mismatch("key_code", 64'(key_code), 64'(want.code));
        end
        if (key_position !== want.pos) begin
          report_mismatch("key_position", 64'(key_position), 64'(want.pos));
        end
        if (last_event !== want.last) begin
          report_mismatch("last_event", 64'(last_event), 64'(want.last));
        end
        events_seen++;
        if (want.last) reports_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : sender
    logic [15:0] phase_settle;
    for (int p = 0; p < 64; p++) held_code[p] = 9'd0;

    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd0, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd1, 32'd100, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd1, 32'd110, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd1, 32'd120, 1'b1, 2'd2, EV_PRESS, 9'd116, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd130, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd150, 1'b1, 2'd2, EV_RELEASE, 9'd116, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd1 << 8, 32'd200, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd1 << 8, 32'd220, 1'b1, 2'd1, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, SYMK | (64'd1 << 32), 32'd300,
                              1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, SYMK | (64'd1 << 32), 32'd320,
                              1'b1, 2'd1, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, MODS | SYMK | (64'd1 << 16) | (64'd1 << 63), 32'd400,
                              1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, MODS | SYMK | (64'd1 << 16) | (64'd1 << 63), 32'd420,
                              1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, '1, 32'd600, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, '1, 32'd620, 1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd700, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd720, 1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd2, 32'hFFFF_FFF0,
                              1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd2, 32'h0000_0003,
                              1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd2, 32'h0000_0004,
                              1'b1, 2'd2, EV_PRESS, 9'd217, 6'd1));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd100, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd90, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'h8000_0078,
                              1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'h8000_0077,
                              1'b1, 2'd2, EV_RELEASE, 9'd217, 6'd1));
    plan.push_back(plan_entry(ROW_SETTLE, 64'd0, 32'h0000_0000,
                              1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd4, 32'd5, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd4, 32'd5, 1'b1, 2'd2, EV_PRESS, 9'd59, 6'd2));
    plan.push_back(plan_entry(ROW_SETTLE, 64'd0, 32'hA5A5_FFFF,
                              1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_STRAY, 64'd0, 32'h0000_0007,
                              1'b0, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd1000, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd66534, 1'b1, 2'd0, EV_SYNC, 9'd0, 6'd0));
    plan.push_back(plan_entry(ROW_POLL, 64'd0, 32'd66535,
                              1'b1, 2'd2, EV_RELEASE, 9'd59, 6'd2));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].op)
        ROW_POLL: send_poll(plan[i]);
        ROW_SETTLE: set_register(DEBOUNCE_ADDR, plan[i].now);
        default: set_register(UNMAPPED_ADDR, plan[i].now);
      endcase
    end

    clock_ms = 32'hFFFF_F000;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: phase_settle = 16'd0;
        1: phase_settle = 16'd1;
        2: phase_settle = 16'hFFFF;
        3: phase_settle = 16'($urandom_range(2, 300));
        4: phase_settle = RESET_SETTLE;
        default: phase_settle = 16'($urandom_range(0, 65535));
      endcase
      set_register(DEBOUNCE_ADDR, {16'($urandom), phase_settle});
      if (ph == 1) hold_armed = 1'b1;
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      begin : phase_body
        int phase_end;
        phase_end = polls_sent + PHASE_POLLS;
        while (polls_sent < phase_end) run_burst();
      end
    end

    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d polls over %0d debounce settings, %0d reports, %0d key events",
             polls_sent, settings_used, reports_seen, events_seen);
    $display("random part mixed bounces, wrapped and backward timestamps, and a long hold-off");
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/mkdr_pkg.sv
rtl/mkdr_ctrl.sv
rtl/mkdr_datapath.sv
rtl/matrix_keypad_debounce_reporter.sv
tb/testbench.sv
